// ===== src/upd_pkg.sv =====
package upd_pkg;

    localparam int NUM_BINDINGS_DEF = 128;
    localparam int QUEUE_DEPTH_DEF  = 16;

    // The port table is searched this many entries per cycle.
    localparam int LANES  = 8;
    localparam int LANE_W = $clog2(LANES);

    localparam logic [15:0] UDP_HDR_LEN = 16'd8;

    typedef enum logic [1:0] {
        KIND_BIND    = 2'd0,
        KIND_DELIVER = 2'd1,
        KIND_RECEIVE = 2'd2,
        KIND_NOP     = 2'd3
    } upd_kind_t;

    typedef enum logic [2:0] {
        OP_BIND,
        OP_DELIVER,
        OP_RECEIVE,
        OP_MALFORMED,
        OP_NOP
    } upd_op_t;

    typedef enum logic [2:0] {
        STATUS_OK         = 3'd0,
        STATUS_UNBOUND    = 3'd1,
        STATUS_FULL_DROP  = 3'd2,
        STATUS_EMPTY      = 3'd3,
        STATUS_TABLE_FULL = 3'd4,
        STATUS_MALFORMED  = 3'd5
    } upd_status_t;

    typedef enum logic [2:0] {
        ENG_IDLE,
        ENG_SCAN,
        ENG_QREAD,
        ENG_QEXEC,
        ENG_DREAD,
        ENG_RESULT
    } upd_eng_state_t;

    typedef struct packed {
        upd_op_t     op;
        logic [15:0] port;
        logic [31:0] src_addr;
        logic [15:0] src_port;
        logic [15:0] payload_len;
        logic [15:0] buf_handle;
    } upd_cmd_t;

    typedef struct packed {
        logic [31:0] src_addr;
        logic [15:0] src_port;
        logic [15:0] payload_len;
        logic [15:0] buf_handle;
    } upd_desc_t;

    typedef struct packed {
        upd_status_t status;
        logic [31:0] src_addr;
        logic [15:0] src_port;
        logic [15:0] payload_len;
        logic [15:0] buf_handle;
        logic        free_buffer;
    } upd_result_t;

endpackage

// ===== src/upd_ram.sv =====
module upd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                                         clk,
    input  logic                                         wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                             wr_data,
    input  logic                                         rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                             rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem_reg[rd_addr];
        end
    end

endmodule

// ===== src/upd_front.sv =====
module upd_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    output logic             full,
    input  logic [1:0]       kind,
    input  logic [15:0]      port,
    input  logic [31:0]      src_addr,
    input  logic [15:0]      src_port,
    input  logic [15:0]      udp_length,
    input  logic [15:0]      buf_handle,
    output logic             cmd_valid,
    input  logic             cmd_pop,
    output upd_pkg::upd_cmd_t cmd
);

    upd_pkg::upd_cmd_t entry;
    upd_pkg::upd_cmd_t mem_reg [2];
    logic              wr_ptr_reg, wr_ptr_next;
    logic              rd_ptr_reg, rd_ptr_next;
    logic [1:0]        count_reg, count_next;
    logic              do_push, do_pop;

    // A deliver with a length shorter than the header is marked here so the
    // back end never searches for it.
    always_comb
    begin
        entry             = '0;
        entry.port        = port;
        entry.src_addr    = src_addr;
        entry.src_port    = src_port;
        entry.payload_len = udp_length - upd_pkg::UDP_HDR_LEN;
        entry.buf_handle  = buf_handle;
        unique case (kind)
            upd_pkg::KIND_BIND:    entry.op = upd_pkg::OP_BIND;
            upd_pkg::KIND_DELIVER:
            begin
                if (udp_length < upd_pkg::UDP_HDR_LEN)
                begin
                    entry.op = upd_pkg::OP_MALFORMED;
                end
                else
                begin
                    entry.op = upd_pkg::OP_DELIVER;
                end
            end
            upd_pkg::KIND_RECEIVE: entry.op = upd_pkg::OP_RECEIVE;
            default:               entry.op = upd_pkg::OP_NOP;
        endcase
    end

    always_comb
    begin
        full        = (count_reg == 2'd2);
        cmd_valid   = (count_reg != 2'd0);
        cmd         = mem_reg[rd_ptr_reg];
        do_push     = push && !full;
        do_pop      = cmd_pop && cmd_valid;
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= entry;
        end
    end

endmodule

// ===== src/upd_engine.sv =====
module upd_engine #(
    parameter int NUM_BINDINGS = upd_pkg::NUM_BINDINGS_DEF,
    parameter int QUEUE_DEPTH  = upd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cmd_valid,
    output logic                 cmd_pop,
    input  upd_pkg::upd_cmd_t    cmd,
    output logic                 res_valid,
    input  logic                 res_full,
    output upd_pkg::upd_result_t res
);

    localparam int LANES     = upd_pkg::LANES;
    localparam int LANE_W    = upd_pkg::LANE_W;
    localparam int ROWS      = (NUM_BINDINGS + LANES - 1) / LANES;
    localparam int ROW_IDX_W = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int SLOT_W    = ROW_IDX_W + LANE_W;
    localparam int CMP_W     = SLOT_W + 1;
    localparam int FILL_W    = $clog2(NUM_BINDINGS + 1);
    localparam int QPTR_W    = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W    = $clog2(QUEUE_DEPTH + 1);
    localparam int QS_W      = 2 * QPTR_W + QCNT_W;
    localparam int DESC_W    = $bits(upd_pkg::upd_desc_t);

    upd_pkg::upd_eng_state_t state_reg, state_next;
    upd_pkg::upd_cmd_t       cmd_reg, cmd_next;
    upd_pkg::upd_result_t    res_reg, res_next;
    logic [FILL_W-1:0]       fill_reg, fill_next;
    logic [ROW_IDX_W:0]      row_reg, row_next;
    logic [ROW_IDX_W-1:0]    cmp_row_reg, cmp_row_next;
    logic                    cmp_valid_reg, cmp_valid_next;
    logic [SLOT_W-1:0]       slot_reg, slot_next;

    logic [CMP_W-1:0]        fill_ext;
    logic [CMP_W-1:0]        row_base;
    logic                    scan_issue;
    logic                    scan_end;
    logic                    hit_any;
    logic [LANE_W-1:0]       hit_lane;
    logic [15:0]             port_rd [LANES];
    logic [LANES-1:0]        lane_wr_en;
    logic                    alloc_en;
    logic [SLOT_W-1:0]       alloc_slot;

    logic                    qs_wr_en;
    logic [QS_W-1:0]         qs_wr_data;
    logic                    qs_rd_en;
    logic [QS_W-1:0]         qs_rd;
    logic [QPTR_W-1:0]       qs_head, qs_tail, head_inc, tail_inc;
    logic [QCNT_W-1:0]       qs_count;

    logic                    desc_wr_en;
    logic                    desc_rd_en;
    upd_pkg::upd_desc_t      desc_wr;
    logic [DESC_W-1:0]       desc_rd_bits;
    upd_pkg::upd_desc_t      desc_rd;

    // Bound entries always form a prefix of the table, since entries are
    // claimed lowest first and never released. The fill count marks it.
    assign fill_ext   = CMP_W'(fill_reg);
    assign row_base   = {row_reg, LANE_W'(0)};
    assign scan_issue = (state_reg == upd_pkg::ENG_SCAN) && (row_base < fill_ext);
    assign scan_end   = !cmp_valid_reg && !scan_issue;
    assign alloc_slot = SLOT_W'(fill_reg);

    always_comb
    begin
        logic [CMP_W-1:0] lane_idx;
        hit_any  = 1'b0;
        hit_lane = '0;
        for (int l = LANES - 1; l >= 0; l--)
        begin
            lane_idx = {1'b0, cmp_row_reg, LANE_W'(l)};
            if (cmp_valid_reg && (lane_idx < fill_ext) && (port_rd[l] == cmd_reg.port))
            begin
                hit_any  = 1'b1;
                hit_lane = LANE_W'(l);
            end
        end
    end

    generate
        for (genvar l = 0; l < LANES; l++)
        begin : g_lane
            assign lane_wr_en[l] = alloc_en && (alloc_slot[LANE_W-1:0] == LANE_W'(l));

            upd_ram #(
                .WIDTH(16),
                .DEPTH(ROWS)
            ) u_port_ram (
                .clk     (clk),
                .wr_en   (lane_wr_en[l]),
                .wr_addr (alloc_slot[SLOT_W-1:LANE_W]),
                .wr_data (cmd_reg.port),
                .rd_en   (scan_issue),
                .rd_addr (row_reg[ROW_IDX_W-1:0]),
                .rd_data (port_rd[l])
            );
        end
    endgenerate

    upd_ram #(
        .WIDTH(QS_W),
        .DEPTH(2 ** SLOT_W)
    ) u_qstate_ram (
        .clk     (clk),
        .wr_en   (qs_wr_en),
        .wr_addr (alloc_en ? alloc_slot : slot_reg),
        .wr_data (qs_wr_data),
        .rd_en   (qs_rd_en),
        .rd_addr (slot_reg),
        .rd_data (qs_rd)
    );

    upd_ram #(
        .WIDTH(DESC_W),
        .DEPTH(2 ** (SLOT_W + QPTR_W))
    ) u_desc_ram (
        .clk     (clk),
        .wr_en   (desc_wr_en),
        .wr_addr ({slot_reg, qs_tail}),
        .wr_data (desc_wr),
        .rd_en   (desc_rd_en),
        .rd_addr ({slot_reg, qs_head}),
        .rd_data (desc_rd_bits)
    );

    assign qs_head  = qs_rd[QS_W-1 -: QPTR_W];
    assign qs_tail  = qs_rd[QCNT_W +: QPTR_W];
    assign qs_count = qs_rd[QCNT_W-1:0];
    assign head_inc = (qs_head == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : qs_head + 1'b1;
    assign tail_inc = (qs_tail == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : qs_tail + 1'b1;
    assign desc_rd  = upd_pkg::upd_desc_t'(desc_rd_bits);

    always_comb
    begin
        desc_wr             = '0;
        desc_wr.src_addr    = cmd_reg.src_addr;
        desc_wr.src_port    = cmd_reg.src_port;
        desc_wr.payload_len = cmd_reg.payload_len;
        desc_wr.buf_handle  = cmd_reg.buf_handle;
    end

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        res_next       = res_reg;
        fill_next      = fill_reg;
        row_next       = row_reg;
        cmp_row_next   = cmp_row_reg;
        cmp_valid_next = 1'b0;
        slot_next      = slot_reg;
        cmd_pop        = 1'b0;
        alloc_en       = 1'b0;
        qs_wr_en       = 1'b0;
        qs_wr_data     = '0;
        qs_rd_en       = 1'b0;
        desc_wr_en     = 1'b0;
        desc_rd_en     = 1'b0;
        res_valid      = 1'b0;

        unique case (state_reg)
            upd_pkg::ENG_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_pop  = 1'b1;
                    cmd_next = cmd;
                    row_next = '0;
                    res_next = '0;
                    unique case (cmd.op)
                        upd_pkg::OP_MALFORMED:
                        begin
                            res_next.status      = upd_pkg::STATUS_MALFORMED;
                            res_next.buf_handle  = cmd.buf_handle;
                            res_next.free_buffer = 1'b1;
                            state_next           = upd_pkg::ENG_RESULT;
                        end
                        upd_pkg::OP_BIND, upd_pkg::OP_DELIVER, upd_pkg::OP_RECEIVE:
                        begin
                            state_next = upd_pkg::ENG_SCAN;
                        end
                        default:
                        begin
                            res_next.status = upd_pkg::STATUS_OK;
                            state_next      = upd_pkg::ENG_RESULT;
                        end
                    endcase
                end
            end

            upd_pkg::ENG_SCAN:
            begin
                // One row is read per cycle; its ports are compared in the following cycle.
                cmp_valid_next = scan_issue;
                cmp_row_next   = row_reg[ROW_IDX_W-1:0];
                if (scan_issue)
                begin
                    row_next = row_reg + 1'b1;
                end
                res_next = '0;
                if (hit_any)
                begin
                    cmp_valid_next = 1'b0;
                    slot_next      = {cmp_row_reg, hit_lane};
                    if (cmd_reg.op == upd_pkg::OP_BIND)
                    begin
                        res_next.status = upd_pkg::STATUS_OK;
                        state_next      = upd_pkg::ENG_RESULT;
                    end
                    else
                    begin
                        state_next = upd_pkg::ENG_QREAD;
                    end
                end
                else if (scan_end)
                begin
                    state_next = upd_pkg::ENG_RESULT;
                    unique case (cmd_reg.op)
                        upd_pkg::OP_BIND:
                        begin
                            if (fill_reg < FILL_W'(NUM_BINDINGS))
                            begin
                                // A fresh entry starts with an empty queue.
                                alloc_en        = 1'b1;
                                qs_wr_en        = 1'b1;
                                qs_wr_data      = '0;
                                fill_next       = fill_reg + 1'b1;
                                res_next.status = upd_pkg::STATUS_OK;
                            end
                            else
                            begin
                                res_next.status = upd_pkg::STATUS_TABLE_FULL;
                            end
                        end
                        upd_pkg::OP_DELIVER:
                        begin
                            res_next.status      = upd_pkg::STATUS_UNBOUND;
                            res_next.buf_handle  = cmd_reg.buf_handle;
                            res_next.free_buffer = 1'b1;
                        end
                        default:
                        begin
                            res_next.status = upd_pkg::STATUS_UNBOUND;
                        end
                    endcase
                end
            end

            upd_pkg::ENG_QREAD:
            begin
                qs_rd_en   = 1'b1;
                state_next = upd_pkg::ENG_QEXEC;
            end

            upd_pkg::ENG_QEXEC:
            begin
                res_next   = '0;
                state_next = upd_pkg::ENG_RESULT;
                if (cmd_reg.op == upd_pkg::OP_DELIVER)
                begin
                    if (qs_count == QCNT_W'(QUEUE_DEPTH))
                    begin
                        res_next.status      = upd_pkg::STATUS_FULL_DROP;
                        res_next.buf_handle  = cmd_reg.buf_handle;
                        res_next.free_buffer = 1'b1;
                    end
                    else
                    begin
                        desc_wr_en      = 1'b1;
                        qs_wr_en        = 1'b1;
                        qs_wr_data      = {qs_head, tail_inc, qs_count + 1'b1};
                        res_next.status = upd_pkg::STATUS_OK;
                    end
                end
                else
                begin
                    if (qs_count == '0)
                    begin
                        res_next.status = upd_pkg::STATUS_EMPTY;
                    end
                    else
                    begin
                        desc_rd_en = 1'b1;
                        qs_wr_en   = 1'b1;
                        qs_wr_data = {head_inc, qs_tail, qs_count - 1'b1};
                        state_next = upd_pkg::ENG_DREAD;
                    end
                end
            end

            upd_pkg::ENG_DREAD:
            begin
                res_next             = '0;
                res_next.status      = upd_pkg::STATUS_OK;
                res_next.src_addr    = desc_rd.src_addr;
                res_next.src_port    = desc_rd.src_port;
                res_next.payload_len = desc_rd.payload_len;
                res_next.buf_handle  = desc_rd.buf_handle;
                res_next.free_buffer = 1'b1;
                state_next           = upd_pkg::ENG_RESULT;
            end

            upd_pkg::ENG_RESULT:
            begin
                res_valid = 1'b1;
                if (!res_full)
                begin
                    state_next = upd_pkg::ENG_IDLE;
                end
            end

            default:
            begin
                state_next = upd_pkg::ENG_IDLE;
            end
        endcase
    end

    assign res = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= upd_pkg::ENG_IDLE;
            fill_reg      <= '0;
            row_reg       <= '0;
            cmp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            row_reg       <= row_next;
            cmp_valid_reg <= cmp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg     <= cmd_next;
        res_reg     <= res_next;
        cmp_row_reg <= cmp_row_next;
        slot_reg    <= slot_next;
    end

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_W'(NUM_BINDINGS))
        else $error("binding count exceeds table size");

    a_alloc_step: assert property (@(posedge clk) disable iff (!rst_n)
        alloc_en |=> (fill_reg == FILL_W'($past(fill_reg) + 1'b1)))
        else $error("binding count did not advance on a claim");

    a_qcount_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == upd_pkg::ENG_QEXEC) |-> (qs_count <= QCNT_W'(QUEUE_DEPTH)))
        else $error("queue count above queue depth");

    a_dequeue_result: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == upd_pkg::ENG_DREAD) |=>
            ((res_reg.status == upd_pkg::STATUS_OK) && res_reg.free_buffer))
        else $error("dequeued item not reported as consumed");

endmodule

// ===== src/upd_outq.sv =====
module upd_outq (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 res_push,
    output logic                 res_full,
    input  upd_pkg::upd_result_t res_in,
    output logic                 empty,
    input  logic                 pop,
    output upd_pkg::upd_result_t res_out
);

    upd_pkg::upd_result_t mem_reg [2];
    logic                 wr_ptr_reg, wr_ptr_next;
    logic                 rd_ptr_reg, rd_ptr_next;
    logic [1:0]           count_reg, count_next;
    logic                 do_push, do_pop;

    always_comb
    begin
        res_full    = (count_reg == 2'd2);
        empty       = (count_reg == 2'd0);
        res_out     = mem_reg[rd_ptr_reg];
        do_push     = res_push && !res_full;
        do_pop      = pop && !empty;
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= res_in;
        end
    end

endmodule

// ===== src/udp_port_demux_queues.sv =====
// A short deliver or an undefined kind goes straight to the result; a dequeue passes through the
// port table search, a queue state read and a descriptor read, and the search reads the rows of
// eight bound ports in turn until it finds the port.
// The engine holds one item at a time and takes a new item only when it is through with the last;
// the search reads one row of eight port entries per cycle.
// Reset: rst_n clears the queues, the engine and the binding count at once; the memories need
// no clearing pass.
module udp_port_demux_queues #(
    parameter int NUM_BINDINGS = upd_pkg::NUM_BINDINGS_DEF,
    parameter int QUEUE_DEPTH  = upd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  kind,
    input  logic [15:0] port,
    input  logic [31:0] src_addr,
    input  logic [15:0] src_port,
    input  logic [15:0] udp_length,
    input  logic [15:0] buf_handle,
    output logic        empty,
    input  logic        pop,
    output logic [2:0]  status,
    output logic [31:0] out_src_addr,
    output logic [15:0] out_src_port,
    output logic [15:0] payload_len,
    output logic [15:0] out_buf_handle,
    output logic        free_buffer
);

    upd_pkg::upd_cmd_t    cmd;
    logic                 cmd_valid;
    logic                 cmd_pop;
    upd_pkg::upd_result_t res;
    logic                 res_valid;
    logic                 res_full;
    upd_pkg::upd_result_t res_out;

    upd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .kind       (kind),
        .port       (port),
        .src_addr   (src_addr),
        .src_port   (src_port),
        .udp_length (udp_length),
        .buf_handle (buf_handle),
        .cmd_valid  (cmd_valid),
        .cmd_pop    (cmd_pop),
        .cmd        (cmd)
    );

    upd_engine #(
        .NUM_BINDINGS (NUM_BINDINGS),
        .QUEUE_DEPTH  (QUEUE_DEPTH)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_pop   (cmd_pop),
        .cmd       (cmd),
        .res_valid (res_valid),
        .res_full  (res_full),
        .res       (res)
    );

    upd_outq u_outq (
        .clk      (clk),
        .rst_n    (rst_n),
        .res_push (res_valid),
        .res_full (res_full),
        .res_in   (res),
        .empty    (empty),
        .pop      (pop),
        .res_out  (res_out)
    );

    assign status         = res_out.status;
    assign out_src_addr   = res_out.src_addr;
    assign out_src_port   = res_out.src_port;
    assign payload_len    = res_out.payload_len;
    assign out_buf_handle = res_out.buf_handle;
    assign free_buffer    = res_out.free_buffer;

endmodule

// ===== tb/udp_port_demux_queues_test.sv =====
module udp_port_demux_queues_test;

    localparam int NB = upd_pkg::NUM_BINDINGS_DEF;
    localparam int QD = upd_pkg::QUEUE_DEPTH_DEF;
    localparam int HOLD_CYCLES = 600;
    localparam int DRAIN_CYCLES = 40;
    localparam int PHASE_ITEMS = 410;
    localparam int FILL_ITEMS = 140;
    localparam int TAIL_ITEMS = 50;
    localparam longint RUN_LIMIT = 64'd6_000_000;
    localparam logic [15:0] PORT_POOL [6] = '{16'd0, 16'hFFFF, 16'd100, 16'd7, 16'h8000,
                                              16'h1234};

    typedef enum int {
        PH_DIRECTED,
        PH_FREE,
        PH_SEND_IDLE,
        PH_RECV_STALL,
        PH_BOTH
    } traffic_phase_t;

    typedef struct packed {
        upd_pkg::upd_kind_t kind;
        logic [15:0]        port;
        logic [31:0]        src_addr;
        logic [15:0]        src_port;
        logic [15:0]        udp_length;
        logic [15:0]        buf_handle;
    } dgram_item_t;

    typedef struct {
        dgram_item_t          item;
        bit                   typed;
        upd_pkg::upd_status_t want_status;
        logic [15:0]          want_handle;
        bit                   want_free;
    } directed_row_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        push;
    logic        full;
    logic [1:0]  kind;
    logic [15:0] port;
    logic [31:0] src_addr;
    logic [15:0] src_port;
    logic [15:0] udp_length;
    logic [15:0] buf_handle;
    logic        empty;
    logic        pop;
    logic [2:0]  status;
    logic [31:0] out_src_addr;
    logic [15:0] out_src_port;
    logic [15:0] payload_len;
    logic [15:0] out_buf_handle;
    logic        free_buffer;

    traffic_phase_t phase = PH_DIRECTED;

    // Predictor state: binding table and one descriptor queue per binding.
    bit                 bound      [NB];
    logic [15:0]        bound_port [NB];
    upd_pkg::upd_desc_t rx_fifo    [NB][$];

    upd_pkg::upd_result_t pending_results [$];
    directed_row_t        directed_rows [$];
    int                   mismatch_count = 0;
    int                   items_sent = 0;
    int                   status_seen [6];

    udp_port_demux_queues u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .kind           (kind),
        .port           (port),
        .src_addr       (src_addr),
        .src_port       (src_port),
        .udp_length     (udp_length),
        .buf_handle     (buf_handle),
        .empty          (empty),
        .pop            (pop),
        .status         (status),
        .out_src_addr   (out_src_addr),
        .out_src_port   (out_src_port),
        .payload_len    (payload_len),
        .out_buf_handle (out_buf_handle),
        .free_buffer    (free_buffer)
    );

    always #4 clk = ~clk;

    function automatic int idle_pct(input traffic_phase_t ph, input bit receiver_side);
        unique case (ph)
            PH_SEND_IDLE:  return receiver_side ? 0 : 53;
            PH_RECV_STALL: return receiver_side ? 53 : 0;
            PH_BOTH:       return 32;
            default:       return 0;
        endcase
    endfunction

    function automatic int find_binding(input logic [15:0] p);
        for (int i = 0; i < NB; i++)
        begin
            if (bound[i] && bound_port[i] == p)
                return i;
        end
        return -1;
    endfunction

    // Applies one item to the predictor state and returns the result it should produce.
    function automatic upd_pkg::upd_result_t demux_predict(input dgram_item_t it);
        upd_pkg::upd_result_t r;
        upd_pkg::upd_desc_t   d;
        int                   s;
        int                   slot;
        r = '0;
        r.status = upd_pkg::STATUS_OK;
        unique case (it.kind)
            upd_pkg::KIND_BIND:
            begin
                if (find_binding(it.port) < 0)
                begin
                    slot = -1;
                    for (int i = 0; i < NB && slot < 0; i++)
                    begin
                        if (!bound[i])
                            slot = i;
                    end
                    if (slot < 0)
                    begin
                        r.status = upd_pkg::STATUS_TABLE_FULL;
                    end
                    else
                    begin
                        bound[slot] = 1'b1;
                        bound_port[slot] = it.port;
                        rx_fifo[slot].delete();
                    end
                end
            end
            upd_pkg::KIND_DELIVER:
            begin
                s = find_binding(it.port);
                if (it.udp_length < upd_pkg::UDP_HDR_LEN)
                    r.status = upd_pkg::STATUS_MALFORMED;
                else if (s < 0)
                    r.status = upd_pkg::STATUS_UNBOUND;
                else if (rx_fifo[s].size() >= QD)
                    r.status = upd_pkg::STATUS_FULL_DROP;
                if (r.status != upd_pkg::STATUS_OK)
                begin
                    r.buf_handle = it.buf_handle;
                    r.free_buffer = 1'b1;
                end
                else
                begin
                    d.src_addr = it.src_addr;
                    d.src_port = it.src_port;
                    d.payload_len = it.udp_length - upd_pkg::UDP_HDR_LEN;
                    d.buf_handle = it.buf_handle;
                    rx_fifo[s].push_back(d);
                end
            end
            upd_pkg::KIND_RECEIVE:
            begin
                s = find_binding(it.port);
                if (s < 0)
                begin
                    r.status = upd_pkg::STATUS_UNBOUND;
                end
                else if (rx_fifo[s].size() == 0)
                begin
                    r.status = upd_pkg::STATUS_EMPTY;
                end
                else
                begin
                    d = rx_fifo[s].pop_front();
                    r.src_addr = d.src_addr;
                    r.src_port = d.src_port;
                    r.payload_len = d.payload_len;
                    r.buf_handle = d.buf_handle;
                    r.free_buffer = 1'b1;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    // Mostly traffic on a small pool of ports so that queues fill and drain.
    function automatic dgram_item_t random_item(input int deliver_pct);
        dgram_item_t it;
        int          roll;
        it.src_addr = $urandom();
        it.src_port = 16'($urandom_range(65535));
        it.buf_handle = 16'($urandom_range(65535));
        if ($urandom_range(99) < 88)
            it.port = PORT_POOL[$urandom_range(5)];
        else
            it.port = 16'($urandom_range(65535));
        roll = $urandom_range(99);
        if (roll < 6)
            it.kind = upd_pkg::KIND_BIND;
        else if (roll < 6 + deliver_pct)
            it.kind = upd_pkg::KIND_DELIVER;
        else if (roll < 97)
            it.kind = upd_pkg::KIND_RECEIVE;
        else
            it.kind = upd_pkg::KIND_NOP;
        roll = $urandom_range(99);
        if (roll < 5)
            it.udp_length = 16'($urandom_range(7));
        else if (roll < 8)
            it.udp_length = 16'hFFFF;
        else if (roll < 50)
            it.udp_length = 16'($urandom_range(1508, 8));
        else
            it.udp_length = 16'($urandom_range(65535, 8));
        return it;
    endfunction

    task automatic add_row(input upd_pkg::upd_kind_t k, input logic [15:0] p,
                           input logic [31:0] addr, input logic [15:0] sport,
                           input logic [15:0] ulen, input logic [15:0] handle,
                           input bit typed, input upd_pkg::upd_status_t st,
                           input logic [15:0] want_handle, input bit want_free);
        directed_row_t row;
        row.item = '{k, p, addr, sport, ulen, handle};
        row.typed = typed;
        row.want_status = st;
        row.want_handle = want_handle;
        row.want_free = want_free;
        directed_rows.push_back(row);
    endtask

    // Holds the item on the input ports until the block takes it.
    task automatic offer(input dgram_item_t it, input int idle);
        while ($urandom_range(99) < idle)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push <= 1'b1;
        kind <= it.kind;
        port <= it.port;
        src_addr <= it.src_addr;
        src_port <= it.src_port;
        udp_length <= it.udp_length;
        buf_handle <= it.buf_handle;
        @(posedge clk);
        while (full)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic run_random(input traffic_phase_t ph, input int count, input int deliver_pct);
        dgram_item_t it;
        phase <= ph;
        for (int n = 0; n < count; n++)
        begin
            it = random_item(deliver_pct);
            offer(it, idle_pct(ph, 1'b0));
            pending_results.push_back(demux_predict(it));
        end
    endtask

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want)
        begin
            mismatch_count++;
            $display("%0t: %s expected %h actual %h", $time, name, want, got);
        end
    endfunction

    always @(posedge clk)
    begin : result_check
        upd_pkg::upd_result_t want;
        if (rst_n && pop && !empty)
        begin
            if (pending_results.size() == 0)
            begin
                mismatch_count++;
                $display("%0t: status expected no result actual %0d", $time, status);
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("status", 32'(want.status), 32'(status));
                check_field("out_src_addr", want.src_addr, out_src_addr);
                check_field("out_src_port", 32'(want.src_port), 32'(out_src_port));
                check_field("payload_len", 32'(want.payload_len), 32'(payload_len));
                check_field("out_buf_handle", 32'(want.buf_handle), 32'(out_buf_handle));
                check_field("free_buffer", 32'(want.free_buffer), 32'(free_buffer));
                status_seen[want.status]++;
            end
        end
    end

    // The receiver stops popping for a long while early on, so the block backs up.
    initial
    begin : receiver
        bit hold_done;
        hold_done = 1'b0;
        pop = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (phase == PH_FREE && !hold_done)
            begin
                hold_done = 1'b1;
                pop <= 1'b0;
                repeat (HOLD_CYCLES)
                    @(posedge clk);
            end
            pop <= ($urandom_range(99) >= idle_pct(phase, 1'b1));
        end
    end

    initial
    begin : stimulus
        dgram_item_t          it;
        upd_pkg::upd_result_t want;
        rst_n = 1'b0;
        push = 1'b0;
        kind = upd_pkg::KIND_NOP;
        port = '0;
        src_addr = '0;
        src_port = '0;
        udp_length = '0;
        buf_handle = '0;

        add_row(upd_pkg::KIND_RECEIVE, 16'd100, 32'h0, 16'h0, 16'd0, 16'h0, 1,
                upd_pkg::STATUS_UNBOUND, 16'h0, 0);
        add_row(upd_pkg::KIND_DELIVER, 16'd100, 32'hC0A80001, 16'd53, 16'd20, 16'h1234, 1,
                upd_pkg::STATUS_UNBOUND, 16'h1234, 1);
        add_row(upd_pkg::KIND_DELIVER, 16'd100, 32'h0, 16'h0, 16'd7, 16'h0042, 1,
                upd_pkg::STATUS_MALFORMED, 16'h0042, 1);
        add_row(upd_pkg::KIND_DELIVER, 16'hFFFF, 32'hFFFFFFFF, 16'hFFFF, 16'd0, 16'hFFFF, 1,
                upd_pkg::STATUS_MALFORMED, 16'hFFFF, 1);
        add_row(upd_pkg::KIND_BIND, 16'd0, 32'h0, 16'h0, 16'd0, 16'h0, 1,
                upd_pkg::STATUS_OK, 16'h0, 0);
        add_row(upd_pkg::KIND_BIND, 16'hFFFF, 32'h0, 16'h0, 16'd0, 16'h0, 1,
                upd_pkg::STATUS_OK, 16'h0, 0);
        add_row(upd_pkg::KIND_BIND, 16'd0, 32'h0, 16'h0, 16'd0, 16'h0, 1,
                upd_pkg::STATUS_OK, 16'h0, 0);
        add_row(upd_pkg::KIND_RECEIVE, 16'd0, 32'h0, 16'h0, 16'd0, 16'h0, 1,
                upd_pkg::STATUS_EMPTY, 16'h0, 0);
        add_row(upd_pkg::KIND_DELIVER, 16'd0, 32'hFFFFFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1,
                upd_pkg::STATUS_OK, 16'h0, 0);
        add_row(upd_pkg::KIND_DELIVER, 16'd0, 32'h0, 16'h0, 16'd8, 16'h0, 1,
                upd_pkg::STATUS_OK, 16'h0, 0);
        add_row(upd_pkg::KIND_DELIVER, 16'hFFFF, 32'h0, 16'h0, 16'd7, 16'h0777, 1,
                upd_pkg::STATUS_MALFORMED, 16'h0777, 1);
        add_row(upd_pkg::KIND_DELIVER, 16'hFFFF, 32'h0A000001, 16'd1024, 16'd9, 16'h5555, 1,
                upd_pkg::STATUS_OK, 16'h0, 0);
        add_row(upd_pkg::KIND_RECEIVE, 16'd0, 32'h0, 16'h0, 16'd0, 16'h0, 0,
                upd_pkg::STATUS_OK, 16'h0, 0);
        add_row(upd_pkg::KIND_RECEIVE, 16'd0, 32'h0, 16'h0, 16'd0, 16'h0, 0,
                upd_pkg::STATUS_OK, 16'h0, 0);
        add_row(upd_pkg::KIND_RECEIVE, 16'd0, 32'h0, 16'h0, 16'd0, 16'h0, 1,
                upd_pkg::STATUS_EMPTY, 16'h0, 0);
        add_row(upd_pkg::KIND_RECEIVE, 16'hFFFF, 32'h0, 16'h0, 16'd0, 16'h0, 0,
                upd_pkg::STATUS_OK, 16'h0, 0);
        add_row(upd_pkg::KIND_NOP, 16'hFFFF, 32'hFFFFFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1,
                upd_pkg::STATUS_OK, 16'h0, 0);
        add_row(upd_pkg::KIND_RECEIVE, 16'd1, 32'h0, 16'h0, 16'd0, 16'h0, 1,
                upd_pkg::STATUS_UNBOUND, 16'h0, 0);
        add_row(upd_pkg::KIND_BIND, 16'd100, 32'h0, 16'h0, 16'd0, 16'h0, 1,
                upd_pkg::STATUS_OK, 16'h0, 0);
        add_row(upd_pkg::KIND_DELIVER, 16'd100, 32'h7F000001, 16'h8000, 16'd1480, 16'h00AA, 1,
                upd_pkg::STATUS_OK, 16'h0, 0);
        add_row(upd_pkg::KIND_RECEIVE, 16'd100, 32'h0, 16'h0, 16'd0, 16'h0, 0,
                upd_pkg::STATUS_OK, 16'h0, 0);

        repeat (8)
            @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
        begin
            offer(directed_rows[i].item, 0);
            want = demux_predict(directed_rows[i].item);
            if (directed_rows[i].typed)
            begin
                want = '0;
                want.status = directed_rows[i].want_status;
                want.buf_handle = directed_rows[i].want_handle;
                want.free_buffer = directed_rows[i].want_free;
            end
            pending_results.push_back(want);
        end

        // Delivery-heavy phases push queues to full, receive-heavy ones drain them.
        run_random(PH_FREE, PHASE_ITEMS, 60);
        run_random(PH_SEND_IDLE, PHASE_ITEMS, 38);
        run_random(PH_RECV_STALL, PHASE_ITEMS, 60);
        run_random(PH_BOTH, PHASE_ITEMS, 38);

        // Bind fresh ports until the table runs out of entries.
        phase <= PH_FREE;
        for (int n = 0; n < FILL_ITEMS; n++)
        begin
            it = random_item(0);
            it.kind = upd_pkg::KIND_BIND;
            it.port = 16'($urandom_range(65535));
            offer(it, 0);
            pending_results.push_back(demux_predict(it));
        end
        run_random(PH_FREE, TAIL_ITEMS, 45);
        push <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);

        $display("Run covered %0d items: directed cases, idle and stall mixes, a long backup,",
                 items_sent);
        $display("and a full table; %0d ok, %0d unbound, %0d queue full,",
                 status_seen[0], status_seen[1], status_seen[2]);
        $display("%0d empty, %0d table full, %0d malformed.",
                 status_seen[3], status_seen[4], status_seen[5]);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin : watchdog
        #(RUN_LIMIT);
        $display("%0t: timed out with %0d results outstanding", $time, pending_results.size());
        $display("Mismatches found");
        $finish;
    end

endmodule

// ===== sim.f =====
src/upd_pkg.sv
src/upd_ram.sv
src/upd_front.sv
src/upd_engine.sv
src/upd_outq.sv
src/udp_port_demux_queues.sv
tb/udp_port_demux_queues_test.sv
